// ===== rtl/core/rsd_pkg.sv =====
// Package for the restoring signed divider.
// Holds shared constants, the datapath command type and the datapath status struct.
// No dependencies.
package rsd_pkg;

    localparam int DEFAULT_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Commands from the sequencer to the datapath.
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_STEP,
        CMD_SIGN
    } rsd_cmd_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic                special;
        logic [STATUS_W-1:0] code;
    } rsd_dp_stat_t;

endpackage

// ===== rtl/core/rsd_datapath.sv =====
// Datapath of the restoring signed divider: operand magnitudes, the shared
// shift-subtract unit, sign fix-up and the floor correction on the result.
// Depends on rsd_pkg.
module rsd_datapath
    import rsd_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic             aclk,
    input  rsd_cmd_t         cmd,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    input  logic             floor_mode,
    output rsd_dp_stat_t     stat,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam logic [WIDTH-1:0] ONE      = WIDTH'(1);
    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH-1:0] b_raw_reg, b_raw_next;
    logic             a_neg_reg, a_neg_next;
    logic             b_neg_reg, b_neg_next;
    rsd_dp_stat_t     stat_reg, stat_next;

    logic [WIDTH-1:0] mag_a;
    logic [WIDTH-1:0] mag_b;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH+1:0] diff;
    logic             floor_fix;

    assign mag_a     = dividend[WIDTH-1] ? (~dividend + ONE) : dividend;
    assign mag_b     = divisor[WIDTH-1]  ? (~divisor + ONE)  : divisor;
    assign rem_shift = {rem_reg, quo_reg[WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_comb begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        b_raw_next = b_raw_reg;
        a_neg_next = a_neg_reg;
        b_neg_next = b_neg_reg;
        stat_next  = stat_reg;
        unique case (cmd)
            CMD_LOAD: begin
                a_neg_next = dividend[WIDTH-1];
                b_neg_next = divisor[WIDTH-1];
                b_raw_next = divisor;
                dvs_next   = mag_b;
                if (divisor == '0) begin
                    quo_next  = '0;
                    rem_next  = dividend;
                    stat_next = '{special: 1'b1, code: STATUS_DIV_ZERO};
                end else if (dividend == MOST_NEG && divisor == '1) begin
                    quo_next  = MOST_NEG;
                    rem_next  = '0;
                    stat_next = '{special: 1'b1, code: STATUS_OVERFLOW};
                end else begin
                    quo_next  = mag_a;
                    rem_next  = '0;
                    stat_next = '{special: 1'b0, code: STATUS_OK};
                end
            end
            CMD_STEP: begin
                // The dividend bits shift out of the top of quo_reg while
                // quotient bits shift in at the bottom.
                if (!diff[WIDTH+1]) begin
                    rem_next = diff[WIDTH-1:0];
                    quo_next = {quo_reg[WIDTH-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[WIDTH-1:0];
                    quo_next = {quo_reg[WIDTH-2:0], 1'b0};
                end
            end
            CMD_SIGN: begin
                if (a_neg_reg != b_neg_reg) begin
                    quo_next = ~quo_reg + ONE;
                end
                if (a_neg_reg) begin
                    rem_next = ~rem_reg + ONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        b_raw_reg <= b_raw_next;
        a_neg_reg <= a_neg_next;
        b_neg_reg <= b_neg_next;
        stat_reg  <= stat_next;
    end

    // Floored mode moves a remainder whose sign disagrees with the divisor.
    assign floor_fix = floor_mode && !stat_reg.special && (rem_reg != '0)
                       && (rem_reg[WIDTH-1] != b_neg_reg);

    assign quotient  = floor_fix ? (quo_reg - ONE)       : quo_reg;
    assign remainder = floor_fix ? (rem_reg + b_raw_reg) : rem_reg;
    assign stat      = stat_reg;

endmodule

// ===== rtl/core/restoring_signed_divider_unit.sv =====
// Top level of the restoring signed divider: stream ports, configuration
// register, sequencer and output register. Depends on rsd_pkg and rsd_datapath.
//
// This unit divides a signed dividend by a signed divisor and returns the
// quotient, the remainder and a status code. After acceptance, the single
// shared shift-subtract unit retires one quotient bit per cycle in S_DIV until
// all WIDTH bits are done, S_SIGN applies the operand signs, and S_FIN applies
// the floored-mode correction while loading the result register. Divide by
// zero and the most-negative-by-minus-one overflow are caught on loading and
// go from S_DIV straight to S_FIN. Only one transaction is in flight, but a
// new one may be accepted while the previous result still waits for m_tready.
// floor_mode is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the unit is idle, which the unit itself does not enforce.
// 0 selects truncating division (remainder follows the dividend's sign), 1
// selects floored division (a nonzero remainder follows the divisor's sign).
module restoring_signed_divider_unit
    import rsd_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,    // floor_mode

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*FIELD_W-1:0] s_tdata,        // [31:0] dividend, [63:32] divisor

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*FIELD_W-1:0] m_tdata,        // [31:0] quotient, [63:32] remainder
    output logic [STATUS_W-1:0]  m_tuser         // [1:0] status
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                floor_mode_reg;
    logic                m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0]  m_quo_reg, m_quo_next;
    logic [FIELD_W-1:0]  m_rem_reg, m_rem_next;
    logic [STATUS_W-1:0] m_stat_reg, m_stat_next;

    rsd_cmd_t            cmd;
    rsd_dp_stat_t        dp_stat;
    logic [WIDTH-1:0]    op_a;
    logic [WIDTH-1:0]    op_b;
    logic [WIDTH-1:0]    dp_quo;
    logic [WIDTH-1:0]    dp_rem;
    logic [FIELD_W-1:0]  quo_field;
    logic [FIELD_W-1:0]  rem_field;
    logic                in_xfer;
    logic                out_free;

    // Operands use the low WIDTH bits of each field; a wider datapath sees the
    // field zero-extended. Results are sign-extended or cut back to the field.
    if (WIDTH <= FIELD_W) begin : g_in_narrow
        assign op_a = s_tdata[WIDTH-1:0];
        assign op_b = s_tdata[FIELD_W+WIDTH-1:FIELD_W];
    end else begin : g_in_wide
        assign op_a = {{(WIDTH-FIELD_W){1'b0}}, s_tdata[FIELD_W-1:0]};
        assign op_b = {{(WIDTH-FIELD_W){1'b0}}, s_tdata[2*FIELD_W-1:FIELD_W]};
    end

    if (WIDTH >= FIELD_W) begin : g_out_wide
        assign quo_field = dp_quo[FIELD_W-1:0];
        assign rem_field = dp_rem[FIELD_W-1:0];
    end else begin : g_out_narrow
        assign quo_field = {{(FIELD_W-WIDTH){dp_quo[WIDTH-1]}}, dp_quo};
        assign rem_field = {{(FIELD_W-WIDTH){dp_rem[WIDTH-1]}}, dp_rem};
    end

    rsd_datapath #(
        .WIDTH(WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .cmd       (cmd),
        .dividend  (op_a),
        .divisor   (op_b),
        .floor_mode(floor_mode_reg),
        .stat      (dp_stat),
        .quotient  (dp_quo),
        .remainder (dp_rem)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // The sequencer issues one datapath command per cycle.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = CMD_HOLD;
        m_valid_next = m_valid_reg;
        m_quo_next   = m_quo_reg;
        m_rem_next   = m_rem_reg;
        m_stat_next  = m_stat_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd        = CMD_LOAD;
                    cnt_next   = CNT_W'(WIDTH - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (dp_stat.special) begin
                    state_next = S_FIN;
                end else begin
                    cmd = CMD_STEP;
                    if (cnt_reg == '0) begin
                        state_next = S_SIGN;
                    end else begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            S_SIGN: begin
                cmd        = CMD_SIGN;
                state_next = S_FIN;
            end
            S_FIN: begin
                // Wait here until the result register is free.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_quo_next   = quo_field;
                    m_rem_next   = rem_field;
                    m_stat_next  = dp_stat.code;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            floor_mode_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                floor_mode_reg <= cfg_wr_data;
            end
        end
        m_quo_reg  <= m_quo_next;
        m_rem_reg  <= m_rem_next;
        m_stat_reg <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_rem_reg, m_quo_reg};
    assign m_tuser  = m_stat_reg;

    // An accepted transaction always occupies the sequencer for the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("divider ready right after accepting a transaction");

    // A new result only appears after the sequencer reached its final state.
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result presented without finishing the division");

    // Divide by zero always reports a zero quotient.
    a_div_zero_quotient: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stat_reg == STATUS_DIV_ZERO) |-> (m_quo_reg == '0))
        else $error("divide by zero with a nonzero quotient");

    // Quotient overflow always reports a zero remainder.
    a_overflow_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stat_reg == STATUS_OVERFLOW) |-> (m_rem_reg == '0))
        else $error("quotient overflow with a nonzero remainder");

endmodule
